// File: src/alle_pkg.sv
// Package of the linked list engine: field widths, operation codes, microcode format and program.
package alle_pkg;

    // Fixed widths of the transaction fields.
    localparam int MODE_W = 2;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 64;
    localparam int ST_W   = 2;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 64;

    // Operation codes.
    localparam logic [MODE_W-1:0] MODE_AFTER  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEFORE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEL    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

    // Status codes.
    localparam logic [ST_W-1:0] ST_DONE = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

    // Sequencer jump kinds.
    localparam int JMP_W = 3;
    localparam logic [JMP_W-1:0] J_NEXT     = 3'd0;
    localparam logic [JMP_W-1:0] J_GOTO     = 3'd1;
    localparam logic [JMP_W-1:0] J_WAIT_IN  = 3'd2;
    localparam logic [JMP_W-1:0] J_DISPATCH = 3'd3;
    localparam logic [JMP_W-1:0] J_WAIT_OUT = 3'd4;

    // Result forms selected by the final step of each path.
    localparam int RES_W = 3;
    localparam logic [RES_W-1:0] RES_BAD  = 3'd0;
    localparam logic [RES_W-1:0] RES_FULL = 3'd1;
    localparam logic [RES_W-1:0] RES_READ = 3'd2;
    localparam logic [RES_W-1:0] RES_INS  = 3'd3;
    localparam logic [RES_W-1:0] RES_DEL  = 3'd4;

    // Microprogram addresses.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] S_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] S_LOOK = 4'd1;
    localparam logic [STEP_W-1:0] S_CHK  = 4'd2;
    localparam logic [STEP_W-1:0] S_BAD  = 4'd3;
    localparam logic [STEP_W-1:0] S_READ = 4'd4;
    localparam logic [STEP_W-1:0] S_FULL = 4'd5;
    localparam logic [STEP_W-1:0] S_INS0 = 4'd6;
    localparam logic [STEP_W-1:0] S_INS1 = 4'd7;
    localparam logic [STEP_W-1:0] S_INS2 = 4'd8;
    localparam logic [STEP_W-1:0] S_INSF = 4'd9;
    localparam logic [STEP_W-1:0] S_DEL0 = 4'd10;
    localparam logic [STEP_W-1:0] S_DEL1 = 4'd11;
    localparam logic [STEP_W-1:0] S_DELF = 4'd12;

    typedef struct packed {
        logic [JMP_W-1:0]  jmp;
        logic [STEP_W-1:0] target;
        logic              rd_look;
        logic              lat_look;
        logic              rd_free;
        logic              wr_alloc;
        logic              pop_free;
        logic              wr_self;
        logic              wr_nbr;
        logic              wr_unlink;
        logic              wr_free;
        logic [RES_W-1:0]  res;
    } t_uctl;

    typedef struct packed {
        logic              bad;
        logic              full;
        logic [MODE_W-1:0] mode;
    } t_flags;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_st;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [POS_W-1:0] slot;
        logic [VAL_W-1:0] read_value;
        logic [POS_W-1:0] next_slot;
        logic [POS_W-1:0] prev_slot;
        logic [POS_W-1:0] entry_total;
    } t_result;

    // Control store: one control word per step.
    function automatic t_uctl uc_rom(input logic [STEP_W-1:0] step);
        t_uctl uc;
        uc        = '0;
        uc.jmp    = J_NEXT;
        uc.target = S_IDLE;
        uc.res    = RES_BAD;
        case (step)
            S_IDLE: uc.jmp = J_WAIT_IN;
            S_LOOK: uc.rd_look = 1'b1;
            S_CHK: begin
                uc.lat_look = 1'b1;
                uc.jmp      = J_DISPATCH;
            end
            S_BAD: begin
                uc.jmp = J_WAIT_OUT;
                uc.res = RES_BAD;
            end
            S_READ: begin
                uc.jmp = J_WAIT_OUT;
                uc.res = RES_READ;
            end
            S_FULL: begin
                uc.jmp = J_WAIT_OUT;
                uc.res = RES_FULL;
            end
            S_INS0: begin
                uc.rd_free  = 1'b1;
                uc.wr_alloc = 1'b1;
            end
            S_INS1: begin
                uc.pop_free = 1'b1;
                uc.wr_self  = 1'b1;
            end
            S_INS2: uc.wr_nbr = 1'b1;
            S_INSF: begin
                uc.jmp = J_WAIT_OUT;
                uc.res = RES_INS;
            end
            S_DEL0: uc.wr_unlink = 1'b1;
            S_DEL1: uc.wr_free = 1'b1;
            S_DELF: begin
                uc.jmp = J_WAIT_OUT;
                uc.res = RES_DEL;
            end
            default: uc.jmp = J_GOTO;
        endcase
        return uc;
    endfunction

    // Mapping of the checked operation onto the first step of its path.
    function automatic logic [STEP_W-1:0] dispatch(input t_flags f);
        logic [STEP_W-1:0] tgt;
        tgt = S_BAD;
        if (!f.bad) begin
            case (f.mode)
                MODE_AFTER, MODE_BEFORE: tgt = f.full ? S_FULL : S_INS0;
                MODE_DEL:                tgt = S_DEL0;
                default:                 tgt = S_READ;
            endcase
        end
        return tgt;
    endfunction

endpackage

// File: src/alle_seq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
module alle_seq import alle_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_out_free,
    input  t_flags  i_flags,
    output t_uctl   o_uc,
    output t_seq_st o_st
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uctl             uc;

    assign uc   = uc_rom(r_step);
    assign o_uc = uc;

    always_comb begin
        n_step = r_step;
        case (uc.jmp)
            J_NEXT:     n_step = r_step + 1'b1;
            J_GOTO:     n_step = uc.target;
            J_WAIT_IN:  if (i_accept) n_step = r_step + 1'b1;
            J_DISPATCH: n_step = dispatch(i_flags);
            J_WAIT_OUT: if (i_out_free) n_step = uc.target;
            default:    n_step = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_st.idle = (uc.jmp == J_WAIT_IN);
    assign o_st.done = (uc.jmp == J_WAIT_OUT) && i_out_free;

endmodule

// File: src/alle_dp.sv
// Datapath of the linked list engine: link, flag and data memories, free chain and count.
module alle_dp import alle_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_uctl             i_uc,
    input  logic              i_accept,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [POS_W-1:0]  i_position,
    input  logic [VAL_W-1:0]  i_value,
    output t_flags            o_flags,
    output t_result           o_result
);

    localparam int IW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    logic [IW-1:0]         mem_nxt [CAPACITY];
    logic [IW-1:0]         mem_prv [CAPACITY];
    logic                  mem_use [CAPACITY];
    logic [DATA_WIDTH-1:0] mem_dat [CAPACITY];

    // Transaction registers.
    logic [MODE_W-1:0]     r_mode;
    logic [POS_W-1:0]      r_pos6;
    logic [IW-1:0]         r_pos_idx;
    logic                  r_oob;
    logic [DATA_WIDTH-1:0] r_val;

    // Working registers.
    logic [IW-1:0]         r_a;
    logic [IW-1:0]         r_b;
    logic [DATA_WIDTH-1:0] r_d;
    logic [IW-1:0]         r_f;
    logic [IW-1:0]         r_old_free;

    // List state held in flip-flops.
    logic [IW-1:0]         r_head;
    logic [IW-1:0]         r_tail;
    logic [IW-1:0]         r_free_head;
    logic [FW-1:0]         r_fresh;
    logic [IW-1:0]         r_count;

    // Read port registers.
    logic [IW-1:0]         r_nxt_q;
    logic [IW-1:0]         r_prv_q;
    logic                  r_use_q;
    logic [DATA_WIDTH-1:0] r_dat_q;
    logic                  r_rd_zero;
    logic                  r_rd_fresh;
    logic [IW-1:0]         r_rd_addr;

    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic [IW-1:0]         fresh_nx;
    logic [IW-1:0]         eff_nxt;
    logic [IW-1:0]         eff_prv;
    logic                  eff_use;
    logic [DATA_WIDTH-1:0] eff_dat;
    logic [IW-1:0]         lnk_n;
    logic [IW-1:0]         lnk_p;

    logic                  nxt_we;
    logic [IW-1:0]         nxt_wa;
    logic [IW-1:0]         nxt_wd;
    logic                  prv_we;
    logic [IW-1:0]         prv_wa;
    logic [IW-1:0]         prv_wd;
    logic                  use_we;
    logic [IW-1:0]         use_wa;
    logic                  nxt_mem_we;
    logic                  prv_mem_we;

    assign rd_en   = i_uc.rd_look | i_uc.rd_free;
    assign rd_addr = i_uc.rd_free ? r_free_head : r_pos_idx;

    // Slots at or above the fill mark have never been allocated, so their reads are replaced by
    // the contents of a reset slot; the sentinel's links live in r_head and r_tail.
    assign fresh_nx = (r_rd_addr == LAST_IDX) ? '0 : r_rd_addr + 1'b1;
    assign eff_nxt  = r_rd_zero ? r_head : (r_rd_fresh ? fresh_nx : r_nxt_q);
    assign eff_prv  = r_rd_zero ? r_tail : (r_rd_fresh ? '0 : r_prv_q);
    assign eff_use  = r_rd_zero | (~r_rd_fresh & r_use_q);
    assign eff_dat  = (r_rd_zero | r_rd_fresh) ? '0 : r_dat_q;

    // New links of the allocated slot: after the position, or before it.
    assign lnk_n = (r_mode == MODE_BEFORE) ? r_pos_idx : r_a;
    assign lnk_p = (r_mode == MODE_BEFORE) ? r_b : r_pos_idx;

    always_comb begin
        nxt_we = 1'b0;
        nxt_wa = r_f;
        nxt_wd = lnk_n;
        prv_we = 1'b0;
        prv_wa = r_f;
        prv_wd = lnk_p;
        if (i_uc.wr_self) begin
            nxt_we = 1'b1;
            prv_we = 1'b1;
        end else if (i_uc.wr_nbr) begin
            nxt_we = 1'b1;
            nxt_wa = lnk_p;
            nxt_wd = r_f;
            prv_we = 1'b1;
            prv_wa = lnk_n;
            prv_wd = r_f;
        end else if (i_uc.wr_unlink) begin
            nxt_we = 1'b1;
            nxt_wa = r_b;
            nxt_wd = r_a;
            prv_we = 1'b1;
            prv_wa = r_a;
            prv_wd = r_b;
        end else if (i_uc.wr_free) begin
            nxt_we = 1'b1;
            nxt_wa = r_pos_idx;
            nxt_wd = r_free_head;
            prv_we = 1'b1;
            prv_wa = r_pos_idx;
            prv_wd = '0;
        end
    end

    assign nxt_mem_we = nxt_we && (nxt_wa != '0);
    assign prv_mem_we = prv_we && (prv_wa != '0);
    assign use_we     = i_uc.wr_alloc | i_uc.wr_unlink;
    assign use_wa     = i_uc.wr_alloc ? r_free_head : r_pos_idx;

    always_ff @(posedge i_clk) begin
        if (nxt_mem_we) mem_nxt[nxt_wa] <= nxt_wd;
        if (rd_en) r_nxt_q <= mem_nxt[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (prv_mem_we) mem_prv[prv_wa] <= prv_wd;
        if (rd_en) r_prv_q <= mem_prv[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (use_we) mem_use[use_wa] <= i_uc.wr_alloc;
        if (rd_en) r_use_q <= mem_use[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_uc.wr_alloc) mem_dat[r_free_head] <= r_val;
        if (rd_en) r_dat_q <= mem_dat[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_zero  <= (rd_addr == '0);
            r_rd_fresh <= (FW'(rd_addr) >= r_fresh);
            r_rd_addr  <= rd_addr;
        end
        if (i_accept) begin
            r_mode    <= i_mode;
            r_pos6    <= i_position;
            r_pos_idx <= IW'(i_position);
            r_oob     <= (32'(i_position) >= 32'(CAPACITY));
            r_val     <= i_value[DATA_WIDTH-1:0];
        end
        if (i_uc.lat_look) begin
            r_a <= eff_nxt;
            r_b <= eff_prv;
            r_d <= eff_dat;
        end
        if (i_uc.wr_alloc) r_f <= r_free_head;
        if (i_uc.wr_free) r_old_free <= r_free_head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_free_head <= IW'(1);
            r_fresh     <= FW'(1);
            r_count     <= '0;
        end else begin
            if (nxt_we && (nxt_wa == '0)) r_head <= nxt_wd;
            if (prv_we && (prv_wa == '0)) r_tail <= prv_wd;
            if (i_uc.pop_free) begin
                r_free_head <= eff_nxt;
                if (r_rd_fresh) r_fresh <= r_fresh + 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (i_uc.wr_free) begin
                r_free_head <= r_pos_idx;
                if (r_count != '0) r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_flags.bad  = r_oob | ~eff_use | ((r_mode == MODE_DEL) && (r_pos_idx == '0));
    assign o_flags.full = (r_free_head == '0);
    assign o_flags.mode = r_mode;

    always_comb begin
        o_result.status      = ST_DONE;
        o_result.slot        = r_pos6;
        o_result.read_value  = '0;
        o_result.next_slot   = POS_W'(r_a);
        o_result.prev_slot   = POS_W'(r_b);
        o_result.entry_total = POS_W'(r_count);
        case (i_uc.res)
            RES_BAD: begin
                o_result.status = ST_BAD;
                if (r_oob) begin
                    o_result.next_slot = '0;
                    o_result.prev_slot = '0;
                end
            end
            RES_FULL: o_result.status = ST_FULL;
            RES_READ: o_result.read_value = VAL_W'(r_d);
            RES_INS: begin
                o_result.slot      = POS_W'(r_f);
                o_result.next_slot = POS_W'(lnk_n);
                o_result.prev_slot = POS_W'(lnk_p);
            end
            RES_DEL: begin
                o_result.next_slot = POS_W'(r_old_free);
                o_result.prev_slot = '0;
            end
            default: ;
        endcase
    end

endmodule

// File: src/array_linked_list_engine_top.sv
// Top level of the array linked list engine: handshakes, sequencer, datapath, result register.
// Input channel: i_in_valid with o_in_stall carries i_mode, i_position and i_value; a
// transaction is taken when valid is high and stall is low. o_in_stall is low only while the
// sequencer waits in its idle step, so one operation is in flight at a time.
// Output channel: o_out_valid with i_out_stall carries one result per operation, held in an
// output register until the receiver takes it.
// Every operation runs the look-up and check steps and ends in a result step; an insert
// first runs the allocate, link and neighbour-link steps, a delete the unlink and free
// steps. The length of each path is set by the microprogram, since every step makes at
// most one access to each single-port link memory.
// When the receiver stalls, the finished operation waits in its last step until the output
// register can be loaded, and no new transaction is taken in the meantime.
// Reset (synchronous, active low) empties the list, points the free chain at slot 1 and clears
// the entry count. A fill mark stands in for the reset contents of never-used slots, so no
// clearing pass runs and the block is ready as soon as reset is released.
module array_linked_list_engine_top import alle_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [POS_W-1:0]  i_position,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ST_W-1:0]   o_status,
    output logic [POS_W-1:0]  o_slot,
    output logic [VAL_W-1:0]  o_read_value,
    output logic [POS_W-1:0]  o_next_slot,
    output logic [POS_W-1:0]  o_prev_slot,
    output logic [POS_W-1:0]  o_entry_total
);

    t_uctl   uc;
    t_seq_st st;
    t_flags  flags;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    accept;
    logic    out_free;

    assign accept   = i_in_valid & st.idle;
    assign out_free = ~r_out_valid | ~i_out_stall;

    alle_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_uc       (uc),
        .o_st       (st)
    );

    alle_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uc       (uc),
        .i_accept   (accept),
        .i_mode     (i_mode),
        .i_position (i_position),
        .i_value    (i_value),
        .o_flags    (flags),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (st.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (st.done) r_out <= result;
    end

    assign o_in_stall    = ~st.idle;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_slot        = r_out.slot;
    assign o_read_value  = r_out.read_value;
    assign o_next_slot   = r_out.next_slot;
    assign o_prev_slot   = r_out.prev_slot;
    assign o_entry_total = r_out.entry_total;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench of the array linked list engine: directed and random list operations.
module tb_top;
    import alle_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_START  = 1500;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
    } t_list_op;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [MODE_W-1:0] op_mode = MODE_READ;
    logic [POS_W-1:0]  op_pos = '0;
    logic [VAL_W-1:0]  op_val = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [ST_W-1:0]   res_status;
    logic [POS_W-1:0]  res_slot;
    logic [VAL_W-1:0]  res_read_value;
    logic [POS_W-1:0]  res_next_slot;
    logic [POS_W-1:0]  res_prev_slot;
    logic [POS_W-1:0]  res_entry_total;

    // Expected contents of the list after every accepted transaction.
    logic [VAL_W-1:0] list_data [SLOTS];
    logic [POS_W-1:0] list_next [SLOTS];
    logic [POS_W-1:0] list_prev [SLOTS];
    bit               list_used [SLOTS];
    logic [POS_W-1:0] free_head;
    logic [POS_W-1:0] entry_count;

    // The stimulus generator keeps a rough image of occupancy to aim at live slots.
    bit       gen_used [SLOTS];
    int       gen_free [$];
    int       gen_count;

    t_list_op op_queue [$];
    t_result  awaited_results [$];

    int       mismatches = 0;
    int       cycles = 0;
    int       gap_left = 0;
    int       burst_left = 1;
    int       peak_entries = 0;
    int       n_done = 0;
    int       n_full = 0;
    int       n_bad = 0;
    int       stall_style = 0;
    int       style_left = 0;
    int       hold_left = 0;
    int       recv_cycles = 0;

    array_linked_list_engine_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_mode        (op_mode),
        .i_position    (op_pos),
        .i_value       (op_val),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (res_status),
        .o_slot        (res_slot),
        .o_read_value  (res_read_value),
        .o_next_slot   (res_next_slot),
        .o_prev_slot   (res_prev_slot),
        .o_entry_total (res_entry_total)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Applies one operation to the expected list and returns the result it should give.
    function automatic t_result list_apply(input logic [MODE_W-1:0] mode,
                                           input logic [POS_W-1:0] pos,
                                           input logic [VAL_W-1:0] val);
        t_result r;
        logic [POS_W-1:0] f;
        logic [POS_W-1:0] nb;
        logic [POS_W-1:0] pb;
        r = '0;
        r.status = ST_DONE;
        r.slot = pos;
        if (!list_used[pos] || (mode == MODE_DEL && pos == 0)) begin
            r.status = ST_BAD;
            r.next_slot = list_next[pos];
            r.prev_slot = list_prev[pos];
        end else if (mode == MODE_AFTER || mode == MODE_BEFORE) begin
            if (free_head == 0) begin
                r.status = ST_FULL;
                r.next_slot = list_next[pos];
                r.prev_slot = list_prev[pos];
            end else begin
                f = free_head;
                free_head = list_next[f];
                list_data[f] = val;
                list_used[f] = 1'b1;
                if (mode == MODE_AFTER) begin
                    nb = list_next[pos];
                    list_next[f] = nb;
                    list_prev[f] = pos;
                    list_prev[nb] = f;
                    list_next[pos] = f;
                end else begin
                    pb = list_prev[pos];
                    list_prev[f] = pb;
                    list_next[f] = pos;
                    list_next[pb] = f;
                    list_prev[pos] = f;
                end
                entry_count++;
                r.slot = f;
                r.next_slot = list_next[f];
                r.prev_slot = list_prev[f];
            end
        end else if (mode == MODE_DEL) begin
            nb = list_next[pos];
            pb = list_prev[pos];
            list_data[pos] = '0;
            list_next[pb] = nb;
            list_prev[nb] = pb;
            list_next[pos] = free_head;
            list_prev[pos] = '0;
            list_used[pos] = 1'b0;
            free_head = pos;
            if (entry_count > 0) entry_count--;
            r.next_slot = list_next[pos];
            r.prev_slot = list_prev[pos];
        end else begin
            r.read_value = list_data[pos];
            r.next_slot = list_next[pos];
            r.prev_slot = list_prev[pos];
        end
        r.entry_total = entry_count;
        return r;
    endfunction

    task automatic queue_op(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
                            input logic [VAL_W-1:0] v);
        t_list_op op;
        op.mode = m;
        op.pos = p;
        op.val = v;
        op_queue.push_back(op);
        if (gen_used[p] && (m == MODE_AFTER || m == MODE_BEFORE) && gen_free.size() > 0) begin
            gen_used[gen_free.pop_front()] = 1'b1;
            gen_count++;
        end else if (gen_used[p] && m == MODE_DEL && p != 0) begin
            gen_used[p] = 1'b0;
            gen_free.push_front(p);
            gen_count--;
        end
    endtask

    function automatic logic [POS_W-1:0] pick_used(input bit with_sentinel);
        logic [POS_W-1:0] cand [$];
        for (int i = with_sentinel ? 0 : 1; i < SLOTS; i++) begin
            if (gen_used[i]) cand.push_back(POS_W'(i));
        end
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function automatic logic [VAL_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            2: return VAL_W'(1) << $urandom_range(0, VAL_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    initial begin : stimulus
        bit grow;
        int full_hits;
        int low_mark;
        int r;
        int ins_pct;
        int del_pct;
        int total_ops;
        logic [POS_W-1:0] p;

        for (int i = 0; i < SLOTS; i++) begin
            list_data[i] = '0;
            list_prev[i] = '0;
            list_used[i] = 1'b0;
            list_next[i] = (i + 1 < SLOTS) ? POS_W'(i + 1) : '0;
            gen_used[i] = 1'b0;
            if (i > 0) gen_free.push_back(i);
        end
        list_next[0] = '0;
        list_used[0] = 1'b1;
        gen_used[0] = 1'b1;
        free_head = POS_W'(1);
        entry_count = '0;
        gen_count = 0;

        // Directed opening: sentinel rules, unused slots, both insert directions, delete
        // from the middle, head and tail, and reuse of a freed slot.
        queue_op(MODE_READ, 0, '0);
        queue_op(MODE_DEL, 0, '0);
        queue_op(MODE_READ, 5, '1);
        queue_op(MODE_DEL, 63, '0);
        queue_op(MODE_AFTER, 5, 64'h1234);
        queue_op(MODE_BEFORE, 62, '1);
        queue_op(MODE_AFTER, 0, '1);
        queue_op(MODE_BEFORE, 0, '0);
        queue_op(MODE_AFTER, 1, 64'h8000_0000_0000_0001);
        queue_op(MODE_BEFORE, 1, 64'h5555_5555_AAAA_AAAA);
        queue_op(MODE_READ, 1, '0);
        queue_op(MODE_READ, 3, '1);
        queue_op(MODE_READ, 4, '0);
        queue_op(MODE_READ, 2, '0);
        queue_op(MODE_READ, 0, '0);
        queue_op(MODE_DEL, 3, '0);
        queue_op(MODE_READ, 3, '0);
        queue_op(MODE_DEL, 3, '1);
        queue_op(MODE_BEFORE, 2, 64'hFEDC_BA98_7654_3210);
        queue_op(MODE_DEL, 4, '0);
        queue_op(MODE_DEL, 2, '0);
        queue_op(MODE_READ, 63, '1);

        // Random part alternates between filling the store until it refuses inserts and
        // draining it back to a low mark.
        grow = 1'b1;
        full_hits = 0;
        low_mark = 0;
        for (int n = 0; n < 480; n++) begin
            r = $urandom_range(0, 99);
            ins_pct = grow ? 70 : 15;
            del_pct = grow ? 8 : 65;
            if (r < 8) begin
                queue_op(MODE_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, SLOTS - 1)),
                         rand_word());
            end else if (r < 8 + ins_pct) begin
                p = pick_used(1'b1);
                if (gen_free.size() == 0) full_hits++;
                queue_op($urandom_range(0, 1) ? MODE_AFTER : MODE_BEFORE, p, rand_word());
            end else if (r < 8 + ins_pct + del_pct && gen_count > 0) begin
                queue_op(MODE_DEL, pick_used(1'b0), rand_word());
            end else begin
                queue_op(MODE_READ, pick_used(1'b1), rand_word());
            end
            if (grow && full_hits >= 3) begin
                grow = 1'b0;
                full_hits = 0;
                low_mark = $urandom_range(0, 8);
            end else if (!grow && gen_count <= low_mark) begin
                grow = 1'b1;
            end
        end
        total_ops = op_queue.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every queued transaction must come back as a checked result.
        while (n_done + n_full + n_bad < total_ops)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Checked %0d results: %0d completed, %0d refused on a full store, %0d rejected.",
                 n_done + n_full + n_bad, n_done, n_full, n_bad);
        $display("The list held at most %0d entries; %0d field mismatches.",
                 peak_entries, mismatches);
        if (mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Sender: bursts of transactions separated by random gaps; a stalled payload is held.
    always @(posedge i_clk) begin : drive_ops
        t_list_op op;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                awaited_results.push_back(list_apply(op_mode, op_pos, op_val));
                if (int'(entry_count) > peak_entries) peak_entries = entry_count;
            end
            if (!(in_valid && in_stall)) begin
                if (gap_left > 0 || op_queue.size() == 0) begin
                    in_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    op = op_queue.pop_front();
                    in_valid <= 1'b1;
                    op_mode <= op.mode;
                    op_pos <= op.pos;
                    op_val <= op.val;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // Receiver: changes its stall style at random intervals, and once holds off for a
    // long stretch so that the engine backs up into its input channel.
    always @(posedge i_clk) begin : drive_stall
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            recv_cycles++;
            if (recv_cycles == HOLD_START) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (style_left == 0) begin
                    stall_style = $urandom_range(0, 2);
                    style_left = $urandom_range(10, 60);
                end else begin
                    style_left--;
                end
                case (stall_style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= 1'($urandom_range(0, 1));
                    default: out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_result want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("result with nothing awaited: status %0d slot %0d", res_status, res_slot);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("status", want.status, res_status);
                check_field("slot", want.slot, res_slot);
                check_field("read_value", want.read_value, res_read_value);
                check_field("next_slot", want.next_slot, res_next_slot);
                check_field("prev_slot", want.prev_slot, res_prev_slot);
                check_field("entry_total", want.entry_total, res_entry_total);
                case (want.status)
                    ST_DONE: n_done++;
                    ST_FULL: n_full++;
                    default: n_bad++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit with %0d transactions unsent, %0d awaited.",
                     op_queue.size(), awaited_results.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

endmodule
